FILE: rtl/kruskal_pkg.sv
// shared types, widths and helpers for the kruskal spanning tree block
package kruskal_pkg;

  // field widths of the channels
  localparam int END_W    = 10;
  localparam int WEIGHT_W = 32;
  localparam int TOTAL_W  = 64;
  localparam int VCOUNT_W = 11;

  // defaults
  localparam int DEFAULT_MAX_VERTICES = 1024;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_FIND_RD,
    S_FIND_WALK,
    S_COMP_WALK,
    S_UNION_CHILD,
    S_UNION_ROOT,
    S_RESULT
  } state_t;

  // which find the shared walker is running
  typedef enum logic [1:0] {
    PASS_A,
    PASS_B,
    PASS_A2
  } pass_t;

  // saturating signed add of a weight to the running total
  function automatic logic signed [TOTAL_W-1:0] sat_add(
    input logic signed [TOTAL_W-1:0]  total,
    input logic signed [WEIGHT_W-1:0] weight
  );
    logic signed [TOTAL_W:0] sum;
    logic signed [TOTAL_W-1:0] result;
    sum = (TOTAL_W+1)'(total) + (TOTAL_W+1)'(weight);
    if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
      result = sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
    end else begin
      result = sum[TOTAL_W-1:0];
    end
    return result;
  endfunction

endpackage

FILE: rtl/kruskal_ram.sv
// generic single write port, single read port ram with registered read
module kruskal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/kruskal_union_find_mst.sv
// kruskal spanning tree accumulator: edge channel, union-find sequencer, result register
//
// Edges enter on the in_valid/in_ready channel, already sorted by weight upstream.
// Each accepted edge gives exactly one result on the out_valid/out_ready channel:
// whether the edge was taken, the saturating 64-bit running total, the completion
// flag and an echo of is_last_edge. vertex_count is written on the cfg channel,
// which is always ready; write it only while no edge is in flight.
// One shared walker over one ram, with a write and a read port, does all work.
// Each edge not ignored runs three finds (end_a, end_b, then end_a again, after
// the merge if the roots differ); a merge writes the child link, then the root
// size. With union by size a find path is at most log2 of the set size long.
// Ignored edges (out of range, or the tree already complete) run no finds.
// An edge with new_graph set first sweeps the store, one entry per cycle. After
// reset the same sweep runs and in_ready stays low until it ends; cfg writes are
// taken meanwhile.
// The result is held in an output register: the next edge is accepted while it
// waits, but that edge's result is held back until the receiver takes the first.
module kruskal_union_find_mst
  import kruskal_pkg::*;
#(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
  input  logic                       clk,
  input  logic                       rst,
  // edge channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       new_graph,
  input  logic [END_W-1:0]           end_a,
  input  logic [END_W-1:0]           end_b,
  input  logic signed [WEIGHT_W-1:0] edge_weight,
  input  logic                       is_last_edge,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       edge_taken,
  output logic signed [TOTAL_W-1:0]  mst_total,
  output logic                       tree_complete,
  output logic                       total_final,
  // configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [VCOUNT_W-1:0]        cfg_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int SW = VW + 1;
  localparam int WW = VW + SW;
  localparam logic [16:0] MaxV = 17'(MAX_VERTICES);
  localparam logic [VW-1:0] LastIdx = VW'(MAX_VERTICES - 1);

  state_t state, state_next;
  pass_t  pass;

  // control registers
  logic [VCOUNT_W-1:0]       vcount;
  logic                      done;
  logic                      hold;
  logic signed [TOTAL_W-1:0] total;

  // edge registers
  logic [END_W-1:0]           a_q, b_q;
  logic signed [WEIGHT_W-1:0] w_q;
  logic                       last_q;
  logic                       taken;

  // walker registers
  logic [VW-1:0] clr;
  logic [VW-1:0] start_v;
  logic [VW-1:0] cur;
  logic [VW-1:0] root;
  logic [SW-1:0] root_size;
  logic [VW-1:0] la;
  logic [SW-1:0] sz_la;

  // ram port
  logic          ram_we;
  logic [VW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [VW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;
  logic [VW-1:0] rd_parent;
  logic [SW-1:0] rd_size;

  logic          in_range;
  logic          la_wins;
  logic [SW-1:0] merged_size;
  logic          load_out;

  kruskal_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // store word: parent link above, set size below
  assign rd_parent = ram_rdata[WW-1:SW];
  assign rd_size   = ram_rdata[SW-1:0];

  // both ends inside the graph and the store
  assign in_range = ({1'b0, a_q} < vcount) && ({1'b0, b_q} < vcount) &&
                    (17'(a_q) < MaxV) && (17'(b_q) < MaxV);

  // root is lb during the merge
  assign la_wins     = sz_la > root_size;
  assign merged_size = sz_la + root_size;

  assign cfg_ready = 1'b1;
  assign load_out  = (state == S_RESULT) && (!out_valid || out_ready);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram port
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cur;
    ram_wdata  = {root, rd_size};
    ram_raddr  = cur;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = {clr, SW'(1)};
        if (clr == LastIdx) begin
          state_next = hold ? S_CHECK : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = new_graph ? S_CLEAR : S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = (done || !in_range) ? S_RESULT : S_FIND_RD;
      end
      S_FIND_RD: begin
        ram_raddr  = start_v;
        state_next = S_FIND_WALK;
      end
      S_FIND_WALK: begin
        if (rd_parent == cur) begin
          ram_raddr  = start_v;
          state_next = S_COMP_WALK;
        end else begin
          ram_raddr = rd_parent;
        end
      end
      S_COMP_WALK: begin
        if (cur == root) begin
          case (pass)
            PASS_A:  state_next = S_FIND_RD;
            PASS_B:  state_next = (root != la) ? S_UNION_CHILD : S_FIND_RD;
            PASS_A2: state_next = S_RESULT;
            default: state_next = S_RESULT;
          endcase
        end else begin
          // point this node straight at the root and step to its parent
          ram_we    = 1'b1;
          ram_waddr = cur;
          ram_wdata = {root, rd_size};
          ram_raddr = rd_parent;
        end
      end
      S_UNION_CHILD: begin
        ram_we     = 1'b1;
        ram_waddr  = la_wins ? root : la;
        ram_wdata  = la_wins ? {la, root_size} : {root, sz_la};
        state_next = S_UNION_ROOT;
      end
      S_UNION_ROOT: begin
        ram_we     = 1'b1;
        ram_waddr  = la_wins ? la : root;
        ram_wdata  = la_wins ? {la, merged_size} : {root, merged_size};
        state_next = S_FIND_RD;
      end
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= VCOUNT_RESET;
      done      <= 1'b0;
      hold      <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vcount <= cfg_data;
      end
      if (in_valid && in_ready) begin
        hold <= 1'b1;
        if (new_graph) begin
          total <= '0;
          done  <= 1'b0;
        end
      end
      if (state == S_UNION_CHILD) begin
        total <= sat_add(total, w_q);
      end
      if (state == S_COMP_WALK && cur == root && pass == PASS_A2 &&
          17'(root_size) == 17'(vcount)) begin
        done <= 1'b1;
      end
      if (load_out) begin
        hold      <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // edge, walker and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (state == S_CLEAR) begin
      clr <= (clr == LastIdx) ? '0 : clr + VW'(1);
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          a_q    <= end_a;
          b_q    <= end_b;
          w_q    <= edge_weight;
          last_q <= is_last_edge;
          taken  <= 1'b0;
        end
      end
      S_CHECK: begin
        pass    <= PASS_A;
        start_v <= VW'(a_q);
      end
      S_FIND_RD: begin
        cur <= start_v;
      end
      S_FIND_WALK: begin
        if (rd_parent == cur) begin
          root      <= cur;
          root_size <= rd_size;
          cur       <= start_v;
        end else begin
          cur <= rd_parent;
        end
      end
      S_COMP_WALK: begin
        if (cur == root) begin
          if (pass == PASS_A) begin
            la      <= root;
            sz_la   <= root_size;
            pass    <= PASS_B;
            start_v <= VW'(b_q);
          end else if (pass == PASS_B) begin
            pass    <= PASS_A2;
            start_v <= VW'(a_q);
          end
        end else begin
          cur <= rd_parent;
        end
      end
      S_UNION_CHILD: begin
        taken <= 1'b1;
      end
      default: ;
    endcase
    if (load_out) begin
      edge_taken    <= taken;
      mst_total     <= total;
      tree_complete <= done;
      total_final   <= last_q;
    end
  end

  // once complete, only a new graph clears the flag
  assert property (@(posedge clk) disable iff (rst)
    done && !(in_valid && in_ready && new_graph) |=> done)
    else $error("completion flag dropped without a new graph");

  // no store writes while waiting for an edge
  assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we)
    else $error("store written while idle");

  // the walker never leaves the store
  assert property (@(posedge clk) disable iff (rst)
    state == S_FIND_WALK |-> 17'(cur) < MaxV)
    else $error("walker index outside the store");

  // a merge never happens on a completed tree or on an out of range edge
  assert property (@(posedge clk) disable iff (rst)
    state == S_UNION_CHILD |-> !done && in_range)
    else $error("merge after completion or on an out of range edge");

  // a result is only loaded after an edge transfer
  assert property (@(posedge clk) disable iff (rst)
    load_out |-> hold)
    else $error("result loaded without an edge in flight");

endmodule
